### rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and codes for the partition allocator: field widths, item
// actions, placement policies, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 4;
  localparam int AMOUNT_W   = 16;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 5;
  localparam int NUMBER_W   = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;

  typedef logic [ACTION_W-1:0]   action_t;
  typedef logic [INDEX_W-1:0]    index_t;
  typedef logic [AMOUNT_W-1:0]   amount_t;
  typedef logic [MODE_W-1:0]     fit_mode_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [NUMBER_W-1:0]   number_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam action_t ACT_LOAD    = 2'd0;
  localparam action_t ACT_RESTART = 2'd1;
  localparam action_t ACT_ALLOC   = 2'd2;

  localparam fit_mode_t FIT_FIRST = 2'd0;
  localparam fit_mode_t FIT_BEST  = 2'd1;
  localparam fit_mode_t FIT_WORST = 2'd2;

  localparam cfg_addr_t CFG_FIT_MODE    = 2'd0;
  localparam cfg_addr_t CFG_BLOCK_COUNT = 2'd1;

  localparam fit_mode_t FIT_MODE_RESET    = FIT_FIRST;
  localparam count_t    BLOCK_COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESTART,
    ST_SCAN,
    ST_WRITE,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### rtl/core/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_if
// Valid/ready channels of the partition allocator: request words, result
// words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_in_if;
  import fpa_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  index_t  block_index;
  amount_t amount;

  modport source (output valid, output action, output block_index, output amount,
                  input ready);
  modport sink   (input valid, input action, input block_index, input amount,
                  output ready);
endinterface

interface fpa_out_if;
  import fpa_pkg::*;
  logic    valid;
  logic    ready;
  logic    granted;
  number_t block_number;
  amount_t space_left;

  modport source (output valid, output granted, output block_number,
                  output space_left, input ready);
  modport sink   (input valid, input granted, input block_number,
                  input space_left, output ready);
endinterface

interface fpa_cfg_if;
  import fpa_pkg::*;
  logic      valid;
  logic      ready;
  cfg_addr_t index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/fpa_ram.sv
// ----------------------------------------------------------------------------
// fpa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/fit_policy_partition_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator
// Fixed-partition allocator: loaded and free sizes live in two RAMs; an
// allocate word scans the free sizes one entry per cycle under the selected
// placement policy and writes the reduced size back.
// ----------------------------------------------------------------------------
// Load and unused actions go straight to the result; restart copies every loaded
// size into the free-size RAM; allocate scans N = min(block_count, MAX_BLOCKS)
// entries, then writes back. A new word is taken in the cycle after the result is
// registered, so no new word is taken before the last one has its result.
// After reset a clearing pass zeroes both RAMs; no word is accepted until it
// ends. Registers reset to first fit, 16.
`default_nettype none

module fit_policy_partition_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch,
  fpa_cfg_if.sink   cfg_ch
);
  import fpa_pkg::*;

  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW0  = $clog2(MAX_BLOCKS + 1);
  localparam int CW   = (CW0 > COUNT_W) ? CW0 : COUNT_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;

  state_t    state_r, state_nxt;
  fit_mode_t fit_mode_r;
  count_t    block_count_r;
  cnt_t      cnt_r, cnt_nxt;
  logic      rd_v_r, rd_v_nxt;
  addr_t     rd_idx_r, rd_idx_nxt;
  size_t     req_r, req_nxt;
  logic      pick_v_r, pick_v_nxt;
  addr_t     pick_idx_r, pick_idx_nxt;
  size_t     pick_val_r, pick_val_nxt;
  logic      res_granted_r, res_granted_nxt;
  number_t   res_number_r, res_number_nxt;
  amount_t   res_left_r, res_left_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      out_granted_r;
  number_t   out_number_r;
  amount_t   out_left_r;

  logic  in_acc;
  logic  out_free;
  logic  idx_ok;
  cnt_t  lim;
  logic  fit_ok;
  size_t left_val;
  size_t take_val;
  logic  take;

  logic  ld_we;
  addr_t ld_waddr;
  size_t ld_wdata;
  size_t ld_rdata;
  logic  fr_we;
  addr_t fr_waddr;
  size_t fr_wdata;
  size_t fr_rdata;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign idx_ok        = (32'(in_ch.block_index) < 32'(MAX_BLOCKS));
  assign lim           = (CW'(block_count_r) > MAX_C) ? MAX_C : CW'(block_count_r);
  assign fit_ok        = pick_v_r && (pick_val_r >= req_r);
  assign left_val      = pick_val_r - req_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted      = out_granted_r;
  assign out_ch.block_number = out_number_r;
  assign out_ch.space_left   = out_left_r;

  fpa_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_loaded (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_waddr),
    .wdata (ld_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ld_rdata)
  );

  fpa_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_free (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (fr_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == MAX_C - cnt_t'(1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.action)
            ACT_RESTART: state_nxt = ST_RESTART;
            ACT_ALLOC:   state_nxt = ST_SCAN;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_RESTART: begin
        if (cnt_r >= MAX_C) state_nxt = ST_FIN;
      end
      ST_SCAN: begin
        if (cnt_r >= lim) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ld_we    = 1'b0;
    ld_waddr = addr_t'(in_ch.block_index);
    ld_wdata = size_t'(in_ch.amount);
    fr_we    = 1'b0;
    fr_waddr = rd_idx_r;
    fr_wdata = ld_rdata;
    case (state_r)
      ST_CLEAR: begin
        ld_we    = 1'b1;
        ld_waddr = cnt_r[IW-1:0];
        ld_wdata = '0;
        fr_we    = 1'b1;
        fr_waddr = cnt_r[IW-1:0];
        fr_wdata = '0;
      end
      ST_IDLE: begin
        ld_we = in_acc && (in_ch.action == ACT_LOAD) && idx_ok;
      end
      ST_RESTART: begin
        fr_we = rd_v_r;
      end
      ST_WRITE: begin
        fr_we    = fit_ok;
        fr_waddr = pick_idx_r;
        fr_wdata = left_val;
      end
      default: ;
    endcase
  end

  // Policy compare on the entry returned by the free-size RAM
  always_comb begin
    take_val = fr_rdata;
    case (fit_mode_r)
      FIT_BEST:  take = (take_val >= req_r) && (!pick_v_r || take_val < pick_val_r);
      FIT_WORST: take = !pick_v_r || (take_val > pick_val_r);
      default:   take = (take_val >= req_r) && !pick_v_r;
    endcase
  end

  // Datapath next values
  always_comb begin
    cnt_nxt         = cnt_r;
    rd_v_nxt        = 1'b0;
    rd_idx_nxt      = cnt_r[IW-1:0];
    req_nxt         = req_r;
    pick_v_nxt      = pick_v_r;
    pick_idx_nxt    = pick_idx_r;
    pick_val_nxt    = pick_val_r;
    res_granted_nxt = res_granted_r;
    res_number_nxt  = res_number_r;
    res_left_nxt    = res_left_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = (cnt_r == MAX_C - cnt_t'(1)) ? '0 : cnt_r + cnt_t'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt         = '0;
          req_nxt         = size_t'(in_ch.amount);
          pick_v_nxt      = 1'b0;
          res_granted_nxt = 1'b0;
          res_number_nxt  = '0;
          res_left_nxt    = '0;
        end
      end
      ST_RESTART: begin
        if (cnt_r < MAX_C) begin
          rd_v_nxt = 1'b1;
          cnt_nxt  = cnt_r + cnt_t'(1);
        end
      end
      ST_SCAN: begin
        if (cnt_r < lim) begin
          rd_v_nxt = 1'b1;
          cnt_nxt  = cnt_r + cnt_t'(1);
        end
        if (rd_v_r && take) begin
          pick_v_nxt   = 1'b1;
          pick_idx_nxt = rd_idx_r;
          pick_val_nxt = take_val;
        end
      end
      ST_WRITE: begin
        if (fit_ok) begin
          res_granted_nxt = 1'b1;
          res_number_nxt  = number_t'(cnt_t'(pick_idx_r) + cnt_t'(1));
          res_left_nxt    = amount_t'(left_val);
        end
      end
      ST_FIN: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      cnt_r         <= '0;
      rd_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      fit_mode_r    <= FIT_MODE_RESET;
      block_count_r <= BLOCK_COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_FIT_MODE:    fit_mode_r    <= fit_mode_t'(cfg_ch.data);
          CFG_BLOCK_COUNT: block_count_r <= count_t'(cfg_ch.data);
          default: ;
        endcase
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    req_r         <= req_nxt;
    pick_v_r      <= pick_v_nxt;
    pick_idx_r    <= pick_idx_nxt;
    pick_val_r    <= pick_val_nxt;
    res_granted_r <= res_granted_nxt;
    res_number_r  <= res_number_nxt;
    res_left_r    <= res_left_nxt;
    if (state_r == ST_FIN && out_free) begin
      out_granted_r <= res_granted_r;
      out_number_r  <= res_number_r;
      out_left_r    <= res_left_r;
    end
  end

endmodule

`default_nettype wire
